>>> rtl/fwd_pkg.sv
// shared types and constants of the front-end event word deframer
package fwd_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned CHARGE_W  = 14;
  localparam int unsigned CH_WORD_W = 29;
  localparam int unsigned ASIC_W    = 4;
  localparam int unsigned CHAN_W    = 5;
  localparam int unsigned OUT_W     = 296;

  localparam logic [WORD_W-1:0]   TAG_MASK    = 32'hC000_0000;
  localparam logic [WORD_W-1:0]   SYNC_CODE   = 32'h8000_0000;
  localparam logic [WORD_W-1:0]   FOOTER_CODE = 32'hC000_0000;
  localparam logic [CHARGE_W-1:0] THR_RESET   = 14'd1;

  typedef struct packed {
    logic [CHARGE_W-1:0] threshold;
    logic                use_validation;
  } cfg_t;

endpackage

>>> rtl/fwd_ram.sv
// generic single-write, single-read ram with registered read data
module fwd_ram #(
  parameter int unsigned WIDTH = 29,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/fwd_cfg.sv
// apb register file: threshold and validation mode
module fwd_cfg (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  output fwd_pkg::cfg_t cfg_o
);

  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_USE_VALID = 1'b1;

  fwd_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[2])
        REG_THRESHOLD: cfg_d.threshold      = pwdata[fwd_pkg::CHARGE_W-1:0];
        REG_USE_VALID: cfg_d.use_validation = pwdata[0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold      <= fwd_pkg::THR_RESET;
      cfg_q.use_validation <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_THRESHOLD: prdata = {{(32 - fwd_pkg::CHARGE_W){1'b0}}, cfg_q.threshold};
      REG_USE_VALID: prdata = {31'd0, cfg_q.use_validation};
      default:       prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/fwd_ctrl.sv
// frame parser, channel store sequencer and output register
module fwd_ctrl #(
  parameter int unsigned CHANNELS = 32,
  localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
  localparam int unsigned CW = ($clog2(CHANNELS + 1) > 3) ? $clog2(CHANNELS + 1) : 3
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  fwd_pkg::cfg_t                      cfg_i,
  input  logic                               s_valid_i,
  output logic                               s_ready_o,
  input  logic [fwd_pkg::WORD_W-1:0]         s_data_i,
  output logic                               m_valid_o,
  input  logic                               m_ready_i,
  output logic [fwd_pkg::OUT_W-1:0]          m_data_o,
  output logic                               m_last_o,
  output logic                               ram_we_o,
  output logic [AW-1:0]                      ram_waddr_o,
  output logic [fwd_pkg::CH_WORD_W-1:0]      ram_wdata_o,
  output logic                               ram_re_o,
  output logic [AW-1:0]                      ram_raddr_o,
  input  logic [fwd_pkg::CH_WORD_W-1:0]      ram_rdata_i
);

  localparam logic [2:0] PH_SEARCH = 3'd0;
  localparam logic [2:0] PH_HEADER = 3'd1;
  localparam logic [2:0] PH_CHANS  = 3'd2;
  localparam logic [2:0] PH_VALID  = 3'd3;
  localparam logic [2:0] PH_FOOTER = 3'd4;
  localparam logic [2:0] PH_DRAIN  = 3'd5;

  localparam logic [CW-1:0] IDX_HDR_LAST = CW'(3);
  localparam logic [CW-1:0] IDX_VAL_LAST = CW'(2);
  localparam logic [CW-1:0] IDX_CH_LAST  = CW'(CHANNELS - 1);
  localparam logic [AW-1:0] ADDR_LAST    = AW'(CHANNELS - 1);

  logic [2:0]                     phase_q, phase_d;
  logic [CW-1:0]                  idx_q, idx_d;
  logic [fwd_pkg::ASIC_W-1:0]     asic_q;
  logic [31:0]                    evt_q, evc_q, trig_q, val_q, flags_q, pkt_q, pkt_d;
  logic [63:0]                    run_q;
  logic                           had_val_q, had_val_d;
  logic [AW-1:0]                  rd_idx_q, rd_idx_d;
  logic                           rd_pend_q;
  logic                           m_valid_q, m_valid_d, m_last_q;
  logic [fwd_pkg::OUT_W-1:0]      m_data_q;
  logic                           s_fire, issue, load_last;
  logic [fwd_pkg::CHARGE_W-1:0]   hg, lg;
  logic                           keep;
  logic [6:0]                     idx_ext;
  logic [fwd_pkg::OUT_W-1:0]      out_word;

  assign s_ready_o = (phase_q != PH_DRAIN);
  assign s_fire    = s_valid_i & s_ready_o;

  assign ram_we_o    = s_fire && (phase_q == PH_CHANS);
  assign ram_waddr_o = ADDR_LAST - idx_q[AW-1:0];
  assign ram_wdata_o = s_data_i[fwd_pkg::CH_WORD_W-1:0];

  assign issue       = (phase_q == PH_DRAIN) && !rd_pend_q && (!m_valid_q || m_ready_i);
  assign ram_re_o    = issue;
  assign ram_raddr_o = rd_idx_q;
  assign load_last   = rd_pend_q && (rd_idx_q == ADDR_LAST);

  always_comb begin
    phase_d   = phase_q;
    idx_d     = idx_q;
    had_val_d = had_val_q;
    rd_idx_d  = rd_idx_q;
    pkt_d     = pkt_q;
    unique case (phase_q)
      PH_SEARCH: begin
        if (s_fire && ((s_data_i & fwd_pkg::TAG_MASK) == fwd_pkg::SYNC_CODE)) begin
          phase_d = PH_HEADER;
          idx_d   = '0;
        end
      end
      PH_HEADER: begin
        if (s_fire) begin
          idx_d = idx_q + CW'(1);
          if (idx_q == IDX_HDR_LAST) begin
            idx_d   = '0;
            phase_d = PH_CHANS;
          end
        end
      end
      PH_CHANS: begin
        if (s_fire) begin
          idx_d = idx_q + CW'(1);
          if (idx_q == IDX_CH_LAST) begin
            idx_d     = '0;
            had_val_d = cfg_i.use_validation;
            phase_d   = cfg_i.use_validation ? PH_VALID : PH_FOOTER;
          end
        end
      end
      PH_VALID: begin
        if (s_fire) begin
          idx_d = idx_q + CW'(1);
          if (idx_q == IDX_VAL_LAST) begin
            idx_d   = '0;
            phase_d = PH_FOOTER;
          end
        end
      end
      PH_FOOTER: begin
        if (s_fire) begin
          idx_d    = '0;
          rd_idx_d = '0;
          phase_d  = ((s_data_i & fwd_pkg::TAG_MASK) == fwd_pkg::FOOTER_CODE)
                     ? PH_DRAIN : PH_SEARCH;
        end
      end
      PH_DRAIN: begin
        if (rd_pend_q) begin
          rd_idx_d = rd_idx_q + AW'(1);
          if (load_last) begin
            phase_d = PH_SEARCH;
            pkt_d   = pkt_q + 32'd1;
          end
        end
      end
      default: phase_d = PH_SEARCH;
    endcase
  end

  // header fields, written while the packet is parsed
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      if (phase_q == PH_SEARCH) begin
        if ((s_data_i & fwd_pkg::TAG_MASK) == fwd_pkg::SYNC_CODE) begin
          asic_q <= s_data_i[fwd_pkg::ASIC_W-1:0];
        end
      end else if (phase_q == PH_HEADER) begin
        priority case (idx_q)
          CW'(0):  evt_q        <= s_data_i;
          CW'(1):  run_q[31:0]  <= s_data_i;
          CW'(2):  run_q[63:32] <= s_data_i;
          default: evc_q        <= s_data_i;
        endcase
      end else if (phase_q == PH_VALID) begin
        priority case (idx_q)
          CW'(0):  trig_q  <= s_data_i;
          CW'(1):  val_q   <= s_data_i;
          default: flags_q <= s_data_i;
        endcase
      end
    end
  end

  assign hg      = ram_rdata_i[fwd_pkg::CHARGE_W-1:0];
  assign lg      = ram_rdata_i[2*fwd_pkg::CHARGE_W-1:fwd_pkg::CHARGE_W];
  assign keep    = hg > cfg_i.threshold;
  assign idx_ext = 7'(rd_idx_q);

  assign out_word = {
    2'b00,
    keep ? lg : {fwd_pkg::CHARGE_W{1'b0}},
    keep ? hg : {fwd_pkg::CHARGE_W{1'b0}},
    ram_rdata_i[fwd_pkg::CH_WORD_W-1],
    idx_ext[fwd_pkg::CHAN_W-1:0],
    had_val_q ? flags_q : 32'd0,
    had_val_q ? {val_q, trig_q} : 64'd0,
    evc_q,
    run_q,
    evt_q,
    asic_q,
    pkt_q
  };

  always_comb begin
    m_valid_d = m_valid_q;
    if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
    if (rd_pend_q) begin
      m_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_pend_q) begin
      m_data_q <= out_word;
      m_last_q <= load_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_SEARCH;
      idx_q     <= '0;
      had_val_q <= 1'b0;
      rd_idx_q  <= '0;
      rd_pend_q <= 1'b0;
      pkt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      idx_q     <= idx_d;
      had_val_q <= had_val_d;
      rd_idx_q  <= rd_idx_d;
      rd_pend_q <= issue;
      pkt_q     <= pkt_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;
  assign m_last_o  = m_last_q;

endmodule

>>> rtl/frontend_event_word_deframer_top.sv
// top level of the front-end event word deframer
//
//  channel   dir  handshake                      contents
//  s_axis    in   s_axis_tvalid / s_axis_tready  readout stream word
//  m_axis    out  m_axis_tvalid / m_axis_tready  one channel result, tlast on last channel
//  apb       in   psel, penable, pwrite          threshold (0x0), use_validation (0x4)
//
// one input word is taken per cycle while a packet is parsed
// a good footer blocks the input while CHANNELS results are read from the
// channel ram, each one a ram read and then an output register load,
// plus any output stall
// reset is asynchronous and active low; the channel ram is not cleared
// the input reopens as soon as the last result sits in the output register
module frontend_event_word_deframer_top #(
  parameter int unsigned CHANNELS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // data_word
  input  logic [31:0]                   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // packet_number, asic_id, event_timecode, run_timecode, event_counter,
  // trigger_validation_ids, status_flags, channel, hit, charge_hg, charge_lg, pad
  output logic [fwd_pkg::OUT_W-1:0]     m_axis_tdata,
  output logic                          m_axis_tlast,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  fwd_pkg::cfg_t                   cfg;
  logic                            ram_we, ram_re;
  logic [AW-1:0]                   ram_waddr, ram_raddr;
  logic [fwd_pkg::CH_WORD_W-1:0]   ram_wdata, ram_rdata;

  fwd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fwd_ram #(
    .WIDTH (fwd_pkg::CH_WORD_W),
    .DEPTH (CHANNELS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  fwd_ctrl #(
    .CHANNELS (CHANNELS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_data_i    (s_axis_tdata),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata),
    .m_last_o    (m_axis_tlast),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

endmodule

>>> rtl/fwd_checker.sv
// port-level assertions for the deframer top level, bound to it
module fwd_checker #(
  parameter int unsigned CHANNELS = 32
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [fwd_pkg::OUT_W-1:0] m_axis_tdata,
  input logic                      m_axis_tlast
);

  localparam logic [fwd_pkg::CHAN_W-1:0] LAST_CHAN = fwd_pkg::CHAN_W'(CHANNELS - 1);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // input closed while a packet is still draining
  a_drain_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input open during drain");

  // tlast marks the highest channel only
  a_last_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[264:260] == LAST_CHAN)))
    else $error("tlast and channel disagree");

endmodule

bind frontend_event_word_deframer_top fwd_checker #(
  .CHANNELS (CHANNELS)
) u_fwd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

>>> dv/tb_top.sv
// self-checking testbench for the front-end event word deframer
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CHANNELS    = 32;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE      = 2 * CHANNELS + 8;

  localparam logic [2:0] ADDR_THRESHOLD      = 3'd0;
  localparam logic [2:0] ADDR_USE_VALIDATION = 3'd4;

  typedef enum logic [2:0] {
    SEEK_SYNC,
    TAKE_HEADER,
    TAKE_CHANNELS,
    TAKE_VALID,
    TAKE_FOOTER
  } parse_phase_e;

  // tlast on top, then the tdata fields from the highest bit down
  typedef struct packed {
    logic        last;
    logic [1:0]  pad;
    logic [13:0] charge_lg;
    logic [13:0] charge_hg;
    logic        hit;
    logic [4:0]  channel;
    logic [31:0] status_flags;
    logic [63:0] trig_valid_ids;
    logic [31:0] event_counter;
    logic [63:0] run_timecode;
    logic [31:0] event_timecode;
    logic [3:0]  asic_id;
    logic [31:0] packet_number;
  } channel_result_t;

  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [31:0]               s_axis_tdata  = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [fwd_pkg::OUT_W-1:0] m_axis_tdata;
  logic                      m_axis_tlast;
  logic                      psel          = 1'b0;
  logic                      penable       = 1'b0;
  logic                      pwrite        = 1'b0;
  logic [2:0]                paddr         = '0;
  logic [31:0]               pwdata        = '0;
  logic [31:0]               prdata;
  logic                      pready;

  logic [31:0]        word_q[$];
  channel_result_t    expected_channels[$];
  int                 src_idle_pct  = 12;
  int                 sink_idle_pct = 75;
  int                 hold_left     = 0;
  int                 mismatches    = 0;
  int unsigned        cycle_count   = 0;
  bit                 word_taken    = 1'b0;

  // predictor state
  logic [fwd_pkg::CHARGE_W-1:0] thr_cfg = fwd_pkg::THR_RESET;
  logic                val_cfg = 1'b0;
  parse_phase_e        parse_phase = SEEK_SYNC;
  int unsigned         word_idx = 0;
  logic [3:0]          cur_asic = '0;
  logic [31:0]         cur_event_time = '0;
  logic [63:0]         cur_run_time = '0;
  logic [31:0]         cur_event_count = '0;
  logic [31:0]         cur_trigger = '0;
  logic [31:0]         cur_validation = '0;
  logic [31:0]         cur_flags = '0;
  logic [28:0]         chan_mem[CHANNELS];
  logic [31:0]         packets_done = '0;
  logic                pkt_has_valid = 1'b0;

  frontend_event_word_deframer_top #(
    .CHANNELS(CHANNELS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp);
    mismatches++;
    if (mismatches <= 40) begin
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, exp);
    end
  endtask

  task automatic check_result(input channel_result_t got, input channel_result_t exp);
    if (got.packet_number !== exp.packet_number)
      report_mismatch("packet_number", got.packet_number, exp.packet_number);
    if (got.asic_id !== exp.asic_id)
      report_mismatch("asic_id", got.asic_id, exp.asic_id);
    if (got.event_timecode !== exp.event_timecode)
      report_mismatch("event_timecode", got.event_timecode, exp.event_timecode);
    if (got.run_timecode !== exp.run_timecode)
      report_mismatch("run_timecode", got.run_timecode, exp.run_timecode);
    if (got.event_counter !== exp.event_counter)
      report_mismatch("event_counter", got.event_counter, exp.event_counter);
    if (got.trig_valid_ids !== exp.trig_valid_ids)
      report_mismatch("trigger_validation_ids", got.trig_valid_ids, exp.trig_valid_ids);
    if (got.status_flags !== exp.status_flags)
      report_mismatch("status_flags", got.status_flags, exp.status_flags);
    if (got.channel !== exp.channel)
      report_mismatch("channel", got.channel, exp.channel);
    if (got.hit !== exp.hit)
      report_mismatch("hit", got.hit, exp.hit);
    if (got.charge_hg !== exp.charge_hg)
      report_mismatch("charge_hg", got.charge_hg, exp.charge_hg);
    if (got.charge_lg !== exp.charge_lg)
      report_mismatch("charge_lg", got.charge_lg, exp.charge_lg);
    if (got.last !== exp.last)
      report_mismatch("last", got.last, exp.last);
  endtask

  task automatic deframe_word(input logic [31:0] w);
    channel_result_t r;
    logic [28:0]     cw;
    case (parse_phase)
      SEEK_SYNC: begin
        if ((w & fwd_pkg::TAG_MASK) == fwd_pkg::SYNC_CODE) begin
          cur_asic    = w[3:0];
          word_idx    = 0;
          parse_phase = TAKE_HEADER;
        end
      end
      TAKE_HEADER: begin
        case (word_idx)
          0:       cur_event_time     = w;
          1:       cur_run_time[31:0] = w;
          2:       cur_run_time[63:32] = w;
          default: cur_event_count    = w;
        endcase
        word_idx++;
        if (word_idx >= 4) begin
          word_idx    = 0;
          parse_phase = TAKE_CHANNELS;
        end
      end
      TAKE_CHANNELS: begin
        chan_mem[CHANNELS-1-word_idx] = w[28:0];
        word_idx++;
        if (word_idx >= CHANNELS) begin
          word_idx      = 0;
          pkt_has_valid = val_cfg;
          parse_phase   = val_cfg ? TAKE_VALID : TAKE_FOOTER;
        end
      end
      TAKE_VALID: begin
        case (word_idx)
          0:       cur_trigger    = w;
          1:       cur_validation = w;
          default: cur_flags      = w;
        endcase
        word_idx++;
        if (word_idx >= 3) begin
          word_idx    = 0;
          parse_phase = TAKE_FOOTER;
        end
      end
      default: begin
        if ((w & fwd_pkg::TAG_MASK) == fwd_pkg::FOOTER_CODE) begin
          for (int i = 0; i < CHANNELS; i++) begin
            cw = chan_mem[i];
            r = '0;
            r.packet_number  = packets_done;
            r.asic_id        = cur_asic;
            r.event_timecode = cur_event_time;
            r.run_timecode   = cur_run_time;
            r.event_counter  = cur_event_count;
            r.trig_valid_ids = pkt_has_valid ? {cur_validation, cur_trigger} : 64'd0;
            r.status_flags   = pkt_has_valid ? cur_flags : 32'd0;
            r.channel        = 5'(i);
            r.hit            = cw[28];
            if (cw[13:0] > thr_cfg) begin
              r.charge_hg = cw[13:0];
              r.charge_lg = cw[27:14];
            end
            r.last = (i == CHANNELS - 1);
            expected_channels.push_back(r);
          end
          packets_done++;
        end
        word_idx    = 0;
        parse_phase = SEEK_SYNC;
      end
    endcase
  endtask

  // sample both handshakes at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      word_taken = s_axis_tvalid && s_axis_tready;
      if (word_taken) deframe_word(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_channels.size() == 0)
          report_mismatch("unexpected result on channel", m_axis_tdata[264:260], '0);
        else
          check_result({m_axis_tlast, m_axis_tdata}, expected_channels.pop_front());
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || word_taken) begin
        if (word_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= word_q.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
          s_axis_tdata  <= $urandom;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= sink_idle_pct);
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ADDR_THRESHOLD) thr_cfg = data[fwd_pkg::CHARGE_W-1:0];
    else val_cfg = data[0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_words_sent();
    do @(posedge clk_i); while (word_q.size() != 0 || s_axis_tvalid);
  endtask

  task automatic wait_idle();
    wait_words_sent();
    while (expected_channels.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic logic [31:0] noise_word();
    logic [31:0] w;
    w = $urandom;
    if (w[31:30] == 2'b10) w[30] = 1'b1;
    return w;
  endfunction

  function automatic logic [31:0] bad_footer();
    logic [31:0] w;
    w = $urandom;
    if (w[31:30] == 2'b11) w[30] = 1'b0;
    return w;
  endfunction

  function automatic logic [31:0] channel_word(input int ch, input bit directed);
    logic [31:0] w;
    w = $urandom;
    if (directed) begin
      case (ch % 4)
        0:       w[13:0] = 14'd0;
        1:       w[13:0] = 14'd1;
        2:       w[13:0] = 14'd2;
        default: w[13:0] = 14'h3FFF;
      endcase
      w[27:14] = (ch % 2 == 1) ? 14'h3FFF : 14'h0;
      w[28]    = ((ch / 2) % 2 == 1);
      w[31:29] = (ch < CHANNELS / 2) ? 3'b111 : 3'b000;
    end else begin
      case ($urandom_range(3))
        0:       w[13:0] = thr_cfg + 14'($urandom_range(2)) - 14'd1;
        1:       w[13:0] = $urandom_range(1) ? 14'h3FFF : 14'h0;
        default: ;
      endcase
    end
    return w;
  endfunction

  task automatic push_header(input logic [3:0] asic, input logic [31:0] h0,
                             input logic [31:0] h1, input logic [31:0] h2,
                             input logic [31:0] h3);
    word_q.push_back({2'b10, 26'($urandom), asic});
    word_q.push_back(h0);
    word_q.push_back(h1);
    word_q.push_back(h2);
    word_q.push_back(h3);
  endtask

  // words go out in reverse channel order
  task automatic push_channels(input int first, input int count, input bit directed);
    for (int k = first; k < first + count; k++)
      word_q.push_back(channel_word(CHANNELS - 1 - k, directed));
  endtask

  task automatic queue_random_packet();
    int roll;
    int n_ch;
    roll = $urandom_range(99);
    n_ch = CHANNELS;
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) word_q.push_back(noise_word());
    push_header(4'($urandom), $urandom, $urandom, $urandom, $urandom);
    // short or long channel runs push the footer onto the wrong word
    if (roll < 8) n_ch = $urandom_range(CHANNELS - 1);
    else if (roll < 12) n_ch = CHANNELS + $urandom_range(1, 3);
    push_channels(0, n_ch, 1'b0);
    if (val_cfg) repeat (3) word_q.push_back($urandom);
    word_q.push_back((roll >= 12 && roll < 20) ? bad_footer() : {2'b11, 30'($urandom)});
  endtask

  task automatic run_phase(input int src_pct, input int sink_pct, input logic [13:0] thr,
                           input logic val, input int n_pkts, input int hold);
    wait_idle();
    apb_write(ADDR_THRESHOLD, {18'($urandom), thr});
    apb_write(ADDR_USE_VALIDATION, {31'($urandom), val});
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    if (hold > 0) begin
      @(negedge clk_i);
      hold_left = hold;
    end
    repeat (n_pkts) queue_random_packet();
  endtask

  initial begin
    int drain_wait;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // non-sync words while searching
    word_q.push_back(32'h0000_0000);
    word_q.push_back(32'h7FFF_FFFF);
    word_q.push_back(32'hFFFF_FFFF);
    word_q.push_back(32'h4000_0000);
    // extreme packet, header words that look like sync and footer
    push_header(4'hF, 32'hC000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
    push_channels(0, CHANNELS, 1'b1);
    word_q.push_back(32'hFFFF_FFFF);
    // bad footer drops the packet
    push_header(4'h0, $urandom, $urandom, $urandom, $urandom);
    push_channels(0, CHANNELS, 1'b0);
    word_q.push_back(32'h8000_0000);

    // validation mode taken at the last channel word
    wait_idle();
    apb_write(ADDR_THRESHOLD, 32'd0);
    push_header(4'h5, $urandom, $urandom, $urandom, $urandom);
    push_channels(0, CHANNELS - 1, 1'b1);
    wait_idle();
    apb_write(ADDR_USE_VALIDATION, 32'd1);
    push_channels(CHANNELS - 1, 1, 1'b1);
    word_q.push_back(32'hFFFF_FFFF);
    word_q.push_back(32'h0000_0000);
    word_q.push_back(32'hA5A5_5A5A);
    word_q.push_back(32'hC000_0000);

    // threshold applied at the footer
    push_header(4'hA, $urandom, $urandom, $urandom, $urandom);
    push_channels(0, CHANNELS, 1'b1);
    repeat (3) word_q.push_back($urandom);
    wait_idle();
    apb_write(ADDR_THRESHOLD, 32'h3FFF);
    word_q.push_back({2'b11, 30'($urandom)});

    run_phase(12, 75, 14'($urandom_range(300)), 1'b1, 1, 0);
    run_phase(75, 12, 14'd0, 1'b0, 1, 0);
    run_phase(0, 0, 14'($urandom_range(2000)), 1'b1, 2, 400);

    wait_words_sent();
    drain_wait = 0;
    while (expected_channels.size() != 0 && drain_wait < 20000) begin
      @(posedge clk_i);
      drain_wait++;
    end
    repeat (SETTLE) @(posedge clk_i);
    if (expected_channels.size() != 0)
      report_mismatch("results never produced", expected_channels.size(), '0);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
